// File: sv/kalman_angle_bias_filter_macros.svh
// Assertion helpers shared by the filter RTL
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// antecedent holds -> consequent holds in the next cycle
`define KABF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the same cycle
`define KABF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/kabf_pkg.sv
package kabf_pkg;

   // noise terms, covariance and gains carry this many fraction bits
   localparam int COV_FRAC = 24;
   // restoring divider steps: 32-bit magnitude shifted up by COV_FRAC
   localparam int DIV_STEPS = COV_FRAC + 32;
   localparam int DIV_NUM_W = DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W = 2;

   typedef logic signed [31:0] val_type;
   typedef logic        [31:0] noise_type;
   typedef logic        [17:0] dt_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic signed [71:0] wide_type;

   // request codes
   localparam logic REQ_UPDATE    = 1'b0;
   localparam logic REQ_SET_ANGLE = 1'b1;

   // register indexes
   localparam csr_index_type CSR_Q_ANGLE = 2'd0;
   localparam csr_index_type CSR_Q_BIAS  = 2'd1;
   localparam csr_index_type CSR_R_MEAS  = 2'd2;

   localparam noise_type Q_ANGLE_RESET = 32'd16777;
   localparam noise_type Q_BIAS_RESET  = 32'd50332;
   localparam noise_type R_MEAS_RESET  = 32'd503316;

   // divider result toward the sequencer
   typedef struct packed {
      logic    done;
      val_type quot;
   } div_rsp_type;

   // saturate to signed 32 bits
   function automatic val_type sat32(input wide_type x);
      wide_type max_v;
      wide_type min_v;
      max_v = wide_type'(32'sh7FFF_FFFF);
      min_v = wide_type'(32'sh8000_0000);
      if (x > max_v) return 32'sh7FFF_FFFF;
      if (x < min_v) return 32'sh8000_0000;
      return val_type'(x);
   endfunction

   // divide by 2^n, round to nearest, ties toward plus infinity
   function automatic wide_type rnd_shift(input wide_type x, input int n);
      wide_type one;
      one = wide_type'(1);
      return (x + (one <<< (n - 1))) >>> n;
   endfunction

endpackage

// File: sv/kabf_req_if.sv
interface kabf_req_if;
   import kabf_pkg::*;
   logic    valid;
   logic    ready;
   logic    req_type;
   val_type measured_angle;
   val_type gyro_rate;
   dt_type  time_step;
   modport source(output valid, req_type, measured_angle, gyro_rate, time_step,
                  input ready);
   modport sink(input valid, req_type, measured_angle, gyro_rate, time_step,
                output ready);
endinterface

// File: sv/kabf_rsp_if.sv
interface kabf_rsp_if;
   import kabf_pkg::*;
   logic    valid;
   logic    ready;
   val_type angle_estimate;
   val_type unbiased_rate;
   modport source(output valid, angle_estimate, unbiased_rate, input ready);
   modport sink(input valid, angle_estimate, unbiased_rate, output ready);
endinterface

// File: sv/kabf_csr_if.sv
interface kabf_csr_if;
   import kabf_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   noise_type     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: sv/kalman_angle_bias_filter.sv
// Two-state (angle, gyro bias) Kalman filter in fixed point.
// req_chan: one item per transfer. req_type update fuses measured_angle
// (Q16.16 degrees) with gyro_rate (Q16.16 deg/s) over time_step (Q2.16 s);
// req_type set-angle overwrites the angle only.
// rsp_chan: exactly one result per item, angle_estimate and unbiased_rate.
// csr_chan: writes noise registers 0 angle process, 1 bias process,
// 2 measurement (Q8.24); other indexes are ignored. Write only while idle.
// A set-angle result can transfer in the cycle after its input transfer;
// an update result comes later, as it runs on one shared 36x33 multiplier
// used for 10 products and a bit-serial divider run twice for 56 steps.
// One item is in flight at a time: req ready is high only while idle,
// so a new input is taken only after the previous result has transferred.
// Reset clears angle, bias, rate and covariance to zero and loads the
// default noise values. A stalled receiver holds the result steady and
// keeps req ready low until the response transfer completes.
module kalman_angle_bias_filter #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   kabf_req_if.sink   req_chan,
   kabf_rsp_if.source rsp_chan,
   kabf_csr_if.sink   csr_chan
);
   import kabf_pkg::*;
`include "kalman_angle_bias_filter_macros.svh"

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RATE  = 5'd1;
   localparam logic [4:0] ST_MANG  = 5'd2;
   localparam logic [4:0] ST_MDP   = 5'd3;
   localparam logic [4:0] ST_MQB   = 5'd4;
   localparam logic [4:0] ST_PT    = 5'd5;
   localparam logic [4:0] ST_MT    = 5'd6;
   localparam logic [4:0] ST_P00   = 5'd7;
   localparam logic [4:0] ST_D0S   = 5'd8;
   localparam logic [4:0] ST_D0W   = 5'd9;
   localparam logic [4:0] ST_D1S   = 5'd10;
   localparam logic [4:0] ST_D1W   = 5'd11;
   localparam logic [4:0] ST_Y     = 5'd12;
   localparam logic [4:0] ST_K0Y   = 5'd13;
   localparam logic [4:0] ST_K1Y   = 5'd14;
   localparam logic [4:0] ST_K1P00 = 5'd15;
   localparam logic [4:0] ST_K0P00 = 5'd16;
   localparam logic [4:0] ST_K1P01 = 5'd17;
   localparam logic [4:0] ST_K0P01 = 5'd18;
   localparam logic [4:0] ST_LAST  = 5'd19;
   localparam logic [4:0] ST_OUT   = 5'd20;

   logic [4:0] state_ff, state_in;
   val_type    meas_ff, meas_in;
   val_type    gyro_ff, gyro_in;
   dt_type     dt_ff, dt_in;
   val_type    angle_ff, angle_in;
   val_type    bias_ff, bias_in;
   val_type    rate_ff, rate_in;
   val_type    p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [33:0] dp_ff, dp_in;
   logic signed [35:0] t_ff, t_in;
   val_type    k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   noise_type  qa_ff, qb_ff, r_ff;
   logic signed [68:0] prod_ff;

   logic signed [35:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [32:0] dt_s;
   wide_type           rs_f, rs_c;
   logic               div_start;
   val_type            div_num;
   logic signed [33:0] div_den;
   div_rsp_type        div_rsp;

   kabf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = (state_ff == ST_OUT);
   assign rsp_chan.angle_estimate = angle_ff;
   assign rsp_chan.unbiased_rate  = rate_ff;

   // divider operands: k0 from P00, k1 from P10, both over P00 + R
   assign div_start = (state_ff == ST_D0S) || (state_ff == ST_D1S);
   assign div_num   = (state_ff == ST_D0S) ? p00_ff : p10_ff;
   assign div_den   = 34'(wide_type'(p00_ff) + wide_type'({1'b0, r_ff}));

   // shared multiplier operand select
   always_comb begin
      dt_s  = signed'({15'd0, dt_ff});
      mul_a = 36'(rate_ff);
      mul_b = dt_s;
      case (state_ff)
         ST_MANG:  mul_a = 36'(rate_ff);
         ST_MDP:   mul_a = 36'(p11_ff);
         ST_MQB:   mul_a = signed'({4'd0, qb_ff});
         ST_MT:    mul_a = t_ff;
         ST_K0Y:   begin mul_a = 36'(k0_ff); mul_b = 33'(y_ff);   end
         ST_K1Y:   begin mul_a = 36'(k1_ff); mul_b = 33'(y_ff);   end
         ST_K1P00: begin mul_a = 36'(k1_ff); mul_b = 33'(p00_ff); end
         ST_K0P00: begin mul_a = 36'(k0_ff); mul_b = 33'(p00_ff); end
         ST_K1P01: begin mul_a = 36'(k1_ff); mul_b = 33'(p01_ff); end
         ST_K0P01: begin mul_a = 36'(k0_ff); mul_b = 33'(p01_ff); end
         default:  mul_a = 36'(rate_ff);
      endcase
   end

   // sequencer: each state uses the product issued one state earlier
   always_comb begin
      rs_f = rnd_shift(wide_type'(prod_ff), FRAC_BITS);
      rs_c = rnd_shift(wide_type'(prod_ff), COV_FRAC);

      state_in = state_ff;
      meas_in  = meas_ff;
      gyro_in  = gyro_ff;
      dt_in    = dt_ff;
      angle_in = angle_ff;
      bias_in  = bias_ff;
      rate_in  = rate_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      dp_in    = dp_ff;
      t_in     = t_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      y_in     = y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               meas_in = req_chan.measured_angle;
               gyro_in = req_chan.gyro_rate;
               dt_in   = req_chan.time_step;
               if (req_chan.req_type == REQ_SET_ANGLE) begin
                  angle_in = req_chan.measured_angle;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            rate_in  = sat32(wide_type'(gyro_ff) - wide_type'(bias_ff));
            state_in = ST_MANG;
         end
         ST_MANG: state_in = ST_MDP;
         ST_MDP: begin
            angle_in = sat32(wide_type'(angle_ff) + rs_f);
            state_in = ST_MQB;
         end
         ST_MQB: begin
            dp_in    = 34'(rs_f);
            state_in = ST_PT;
         end
         ST_PT: begin
            // project the covariance; t uses the old P01 and P10
            p11_in   = sat32(wide_type'(p11_ff) + rs_f);
            p01_in   = sat32(wide_type'(p01_ff) - wide_type'(dp_ff));
            p10_in   = sat32(wide_type'(p10_ff) - wide_type'(dp_ff));
            t_in     = 36'(wide_type'(dp_ff) - wide_type'(p01_ff) - wide_type'(p10_ff)
                           + wide_type'({1'b0, qa_ff}));
            state_in = ST_MT;
         end
         ST_MT: state_in = ST_P00;
         ST_P00: begin
            p00_in   = sat32(wide_type'(p00_ff) + rs_f);
            state_in = ST_D0S;
         end
         ST_D0S: state_in = ST_D0W;
         ST_D0W: begin
            if (div_rsp.done) begin
               k0_in    = div_rsp.quot;
               state_in = ST_D1S;
            end
         end
         ST_D1S: state_in = ST_D1W;
         ST_D1W: begin
            if (div_rsp.done) begin
               k1_in    = div_rsp.quot;
               state_in = ST_Y;
            end
         end
         ST_Y: begin
            y_in     = sat32(wide_type'(meas_ff) - wide_type'(angle_ff));
            state_in = ST_K0Y;
         end
         ST_K0Y: state_in = ST_K1Y;
         ST_K1Y: begin
            angle_in = sat32(wide_type'(angle_ff) + rs_c);
            state_in = ST_K1P00;
         end
         ST_K1P00: begin
            bias_in  = sat32(wide_type'(bias_ff) + rs_c);
            state_in = ST_K0P00;
         end
         ST_K0P00: begin
            p10_in   = sat32(wide_type'(p10_ff) - rs_c);
            state_in = ST_K1P01;
         end
         ST_K1P01: begin
            p00_in   = sat32(wide_type'(p00_ff) - rs_c);
            state_in = ST_K0P01;
         end
         ST_K0P01: begin
            p11_in   = sat32(wide_type'(p11_ff) - rs_c);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            p01_in   = sat32(wide_type'(p01_ff) - rs_c);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         angle_ff <= '0;
         bias_ff  <= '0;
         rate_ff  <= '0;
         p00_ff   <= '0;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= '0;
         qa_ff    <= Q_ANGLE_RESET;
         qb_ff    <= Q_BIAS_RESET;
         r_ff     <= R_MEAS_RESET;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         rate_ff  <= rate_in;
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
         // register write transfer
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_Q_ANGLE: qa_ff <= csr_chan.data;
               CSR_Q_BIAS:  qb_ff <= csr_chan.data;
               CSR_R_MEAS:  r_ff  <= csr_chan.data;
               default:     ;
            endcase
         end
      end
      meas_ff <= meas_in;
      gyro_ff <= gyro_in;
      dt_ff   <= dt_in;
      dp_ff   <= dp_in;
      t_ff    <= t_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      y_ff    <= y_in;
      prod_ff <= mul_a * mul_b;
   end

   `KABF_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready, "input taken while an item is in flight")
   `KABF_ASSERT_NEXT(a_set_angle, req_chan.valid && req_chan.ready && (req_chan.req_type == REQ_SET_ANGLE), rsp_chan.valid && (rsp_chan.angle_estimate == $past(req_chan.measured_angle)), "set-angle result wrong")
   `KABF_ASSERT_SAME(a_no_overlap, rsp_chan.valid, !req_chan.ready, "ready while a result is pending")
   `KABF_ASSERT_NEXT(a_idle_after_rsp, rsp_chan.valid && rsp_chan.ready, req_chan.ready && !rsp_chan.valid, "no return to idle after response transfer")

endmodule

// File: sv/kabf_div.sv
// Bit-serial restoring divider: (num * 2^COV_FRAC) / den, truncated toward
// zero, saturated to 32 bits; a zero divisor yields zero.
module kabf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  kabf_pkg::val_type     num,
   input  logic signed [33:0]    den,
   output kabf_pkg::div_rsp_type rsp
);
   import kabf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [32:0]          rem_ff, rem_in;
   logic [32:0]          den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;

   logic [31:0] num_mag;
   logic [33:0] den_abs;
   logic [33:0] rem_sh;
   logic [34:0] diff;

   // one quotient bit per cycle
   always_comb begin
      num_mag = num[31] ? (~num + 32'd1) : num;
      den_abs = den[33] ? (~den + 34'd1) : den;
      rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {num_mag, {COV_FRAC{1'b0}}};
         rem_in  = '0;
         den_in  = den_abs[32:0];
         neg_in  = num[31] ^ den[33];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_in = diff[32:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[32:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // sign and saturate the finished quotient
   always_comb begin
      rsp.done = done_ff;
      if (zero_ff) begin
         rsp.quot = '0;
      end else if (!neg_ff) begin
         rsp.quot = (num_ff > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : val_type'(num_ff[31:0]);
      end else begin
         rsp.quot = (num_ff > DIV_NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                         : val_type'(~num_ff[31:0] + 32'd1);
      end
   end

endmodule
